// ===== rtl/cp2rgb_pkg.sv =====
// Shared types, constants and helpers of the camera pixel to RGB converter.
package cp2rgb_pkg;

	// Largest frame sizes that the position counters support.
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int COUNT_LIMIT = 4096;
	localparam int MAX_W_EFF = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;
	localparam int MAX_H_EFF = (MAX_HEIGHT < COUNT_LIMIT) ? MAX_HEIGHT : COUNT_LIMIT;

	localparam int POS_W  = 12;
	localparam int SIZE_W = 13;
	localparam int SUM_W  = 22;

	typedef logic signed [SUM_W-1:0] sum_t;

	// BT.601 coefficients in Q10.
	localparam sum_t K_Y   = 22'sd1192;
	localparam sum_t K_RV  = 22'sd1634;
	localparam sum_t K_GU  = 22'sd401;
	localparam sum_t K_GV  = 22'sd833;
	localparam sum_t K_BU  = 22'sd2066;
	localparam sum_t ROUND = 22'sd512;
	localparam logic [7:0] LUMA_OFS   = 8'd16;
	localparam logic [7:0] CHROMA_OFS = 8'd128;

	typedef enum logic [1:0] {
		FMT_YUY2  = 2'd0,
		FMT_BGR24 = 2'd1,
		FMT_BGRA  = 2'd2
	} fmt_t;

	typedef enum logic [7:0] {
		CFG_FORMAT    = 8'd0,
		CFG_WIDTH     = 8'd1,
		CFG_HEIGHT    = 8'd2,
		CFG_BOTTOM_UP = 8'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] byte_three;
	} in_word_t;

	typedef struct packed {
		logic [7:0]       red_first;
		logic [7:0]       green_first;
		logic [7:0]       blue_first;
		logic [7:0]       red_second;
		logic [7:0]       green_second;
		logic [7:0]       blue_second;
		logic             second_valid;
		logic [POS_W-1:0] dest_row;
		logic [POS_W-1:0] dest_col;
	} out_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Chroma products shared by both lanes.
	typedef struct packed {
		sum_t red_v;
		sum_t green_u;
		sum_t green_v;
		sum_t blue_u;
	} chroma_t;

	// Where the pixels of one word land in the destination frame.
	typedef struct packed {
		logic             yuv;
		logic             second;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} pos_t;

	typedef struct packed {
		logic en_s1;
		logic en_out;
	} pipe_ctl_t;

	// Rounded sum in Q10 to a byte, clamped to 0..255.
	function automatic logic [7:0] to_byte(sum_t t);
		logic [7:0] res;
		if (t[SUM_W-1]) begin
			res = 8'd0;
		end else if (|t[SUM_W-2:18]) begin
			res = 8'd255;
		end else begin
			res = t[17:10];
		end
		return res;
	endfunction

	// Frame size as the counters use it: zero acts as one, large values saturate.
	function automatic logic [SIZE_W-1:0] limit_size(logic [SIZE_W-1:0] v,
		logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] res;
		if (v == '0) begin
			res = SIZE_W'(1);
		end else if (v > maxv) begin
			res = maxv;
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

// ===== rtl/cp2rgb_chroma.sv =====
// Chroma product stage shared by the two color lanes.
module cp2rgb_chroma import cp2rgb_pkg::*; (
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  logic [7:0] u,
	input  logic [7:0] v,
	output chroma_t   chroma_s1
);

	sum_t d;
	sum_t e;

	assign d = sum_t'($signed({1'b0, u})) - sum_t'($signed({1'b0, CHROMA_OFS}));
	assign e = sum_t'($signed({1'b0, v})) - sum_t'($signed({1'b0, CHROMA_OFS}));

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			chroma_s1.red_v   <= e * K_RV;
			chroma_s1.green_u <= d * K_GU;
			chroma_s1.green_v <= e * K_GV;
			chroma_s1.blue_u  <= d * K_BU;
		end
	end

endmodule

// ===== rtl/cp2rgb_lane.sv =====
// One color lane: luma product, then sum, rounding and clamp of one pixel.
module cp2rgb_lane import cp2rgb_pkg::*; (
	input  logic       clk,
	input  pipe_ctl_t  ctl,
	input  logic [7:0] y,
	input  chroma_t    chroma_s1,
	output rgb_t       rgb
);

	sum_t y_ofs;
	sum_t luma_s1;

	assign y_ofs = sum_t'($signed({1'b0, y})) - sum_t'($signed({1'b0, LUMA_OFS}));

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			luma_s1 <= y_ofs * K_Y;
		end
	end

	assign rgb.red   = to_byte(luma_s1 + chroma_s1.red_v + ROUND);
	assign rgb.green = to_byte(luma_s1 - chroma_s1.green_u - chroma_s1.green_v + ROUND);
	assign rgb.blue  = to_byte(luma_s1 + chroma_s1.blue_u + ROUND);

endmodule

// ===== rtl/cp2rgb_frame.sv =====
// Configuration registers and the raster position counters.
module cp2rgb_frame import cp2rgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic              accept,
	output pos_t              pos,
	output logic [SIZE_W-1:0] width_eff
);

	logic [1:0]        format_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              bottom_up_q;
	logic [POS_W-1:0]  col_q;
	logic [POS_W-1:0]  row_q;

	logic [SIZE_W-1:0] height_eff;
	logic [POS_W-1:0]  col;
	logic [POS_W-1:0]  row;
	logic [SIZE_W-1:0] col_next;
	logic [SIZE_W-1:0] row_next;
	logic              cfg_hit;

	assign cfg_ready = 1'b1;

	assign width_eff  = limit_size(width_q, SIZE_W'(MAX_W_EFF));
	assign height_eff = limit_size(height_q, SIZE_W'(MAX_H_EFF));

	// Counters are always in range; the guard only matters if that ever breaks.
	assign col = ({1'b0, col_q} >= width_eff) ? '0 : col_q;
	assign row = ({1'b0, row_q} >= height_eff) ? '0 : row_q;

	always_comb begin
		pos.yuv    = (format_q == FMT_YUY2);
		pos.second = pos.yuv && (({1'b0, col} + SIZE_W'(1)) < width_eff);
		pos.col    = col;
		pos.row    = bottom_up_q ? POS_W'(height_eff - SIZE_W'(1) - {1'b0, row}) : row;
		col_next   = {1'b0, col} + (pos.yuv ? SIZE_W'(2) : SIZE_W'(1));
		row_next   = {1'b0, row} + SIZE_W'(1);
	end

	always_comb begin
		case (cfg_index)
			CFG_FORMAT, CFG_WIDTH, CFG_HEIGHT, CFG_BOTTOM_UP: cfg_hit = cfg_valid;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q    <= FMT_YUY2;
			width_q     <= SIZE_W'(640);
			height_q    <= SIZE_W'(480);
			bottom_up_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FORMAT:    format_q    <= cfg_data[1:0];
				CFG_WIDTH:     width_q     <= cfg_data;
				CFG_HEIGHT:    height_q    <= cfg_data;
				CFG_BOTTOM_UP: bottom_up_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Any register write starts a new frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_next >= width_eff) begin
				col_q <= '0;
				row_q <= (row_next >= height_eff) ? '0 : row_next[POS_W-1:0];
			end else begin
				col_q <= col_next[POS_W-1:0];
				row_q <= row;
			end
		end
	end

endmodule

// ===== rtl/camera_pixel_to_rgb_converter.sv =====
// Top level of the camera pixel to RGB converter: lanes, merge and output register.
//
// Input words arrive on in_valid/in_ready/in_data, one packed four-byte word each.
// Every accepted word gives exactly one result word on out_valid/out_ready/out_data.
// In YUY2 mode the word carries two pixels that share their chroma; two color
// lanes convert them side by side and the merge stage builds the result, with
// the second pixel dropped when the first one ends its row. In the BGR modes
// the bytes pass straight through with red and blue swapped.
// Each word passes two register stages on its way to out_valid: the product
// stage holds the products of the constant multipliers, then the output register
// holds the clamped colors. Throughput is one word per cycle while out_ready
// stays high, set by the two-stage pipeline in which each stage advances as
// soon as the stage after it frees up.
// When the receiver stalls, the product stage still takes one more word, so
// in_ready falls only when both stages are full.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken; a write
// to one of the four defined registers restarts the frame counters at row zero,
// column zero. Reset empties the pipeline and loads YUY2, 640 by 480, top-down order.
module camera_pixel_to_rgb_converter import cp2rgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	pipe_ctl_t         ctl;
	logic              accept;
	pos_t              pos;
	logic [SIZE_W-1:0] width_eff;
	chroma_t           chroma_s1;
	rgb_t              lane_rgb [2];

	logic              s1_valid;
	pos_t              pos_s1;
	in_word_t          word_s1;
	logic              out_valid_q;
	out_word_t         out_data_q;
	out_word_t         merged;

	// A stage moves on when the stage after it is empty or drains this cycle.
	assign ctl.en_out = !out_valid_q || out_ready;
	assign ctl.en_s1  = !s1_valid || ctl.en_out;
	assign in_ready   = ctl.en_s1;
	assign accept     = in_valid && ctl.en_s1;

	cp2rgb_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.pos       (pos),
		.width_eff (width_eff)
	);

	cp2rgb_chroma u_chroma (
		.clk       (clk),
		.ctl       (ctl),
		.u         (in_data.byte_one),
		.v         (in_data.byte_three),
		.chroma_s1 (chroma_s1)
	);

	// Lane zero converts Y0, lane one converts Y1.
	cp2rgb_lane u_lane0 (
		.clk       (clk),
		.ctl       (ctl),
		.y         (in_data.byte_zero),
		.chroma_s1 (chroma_s1),
		.rgb       (lane_rgb[0])
	);

	cp2rgb_lane u_lane1 (
		.clk       (clk),
		.ctl       (ctl),
		.y         (in_data.byte_two),
		.chroma_s1 (chroma_s1),
		.rgb       (lane_rgb[1])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (ctl.en_s1) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1  <= pos;
			word_s1 <= in_data;
		end
	end

	// Merge the lanes, or pass the BGR bytes through, into one result word.
	always_comb begin
		merged = '0;
		merged.dest_row = pos_s1.row;
		merged.dest_col = pos_s1.col;
		if (pos_s1.yuv) begin
			merged.red_first   = lane_rgb[0].red;
			merged.green_first = lane_rgb[0].green;
			merged.blue_first  = lane_rgb[0].blue;
			if (pos_s1.second) begin
				merged.red_second   = lane_rgb[1].red;
				merged.green_second = lane_rgb[1].green;
				merged.blue_second  = lane_rgb[1].blue;
				merged.second_valid = 1'b1;
			end
		end else begin
			merged.red_first   = word_s1.byte_two;
			merged.green_first = word_s1.byte_one;
			merged.blue_first  = word_s1.byte_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.en_out) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_out && s1_valid) begin
			out_data_q <= merged;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The input side only backs up when both pipeline stages hold a word.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid && out_valid_q))
		else $error("in_ready low while the pipeline has room");

	// YUY2 pairs always start on an even column.
	a_pair_even_col: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.second_valid) |-> !out_data_q.dest_col[0])
		else $error("pixel pair starts on an odd column");

	// An absent second pixel carries zero colors.
	a_absent_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.second_valid) |->
			(out_data_q.red_second == 8'd0 && out_data_q.green_second == 8'd0 &&
			 out_data_q.blue_second == 8'd0))
		else $error("absent second pixel has nonzero color");

	// The column counter stays inside the active row.
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, u_frame.col_q} < width_eff))
		else $error("column counter beyond frame width");

endmodule
